### rtl/rate_scaled_tick_accumulator_defines.svh
// Assertion macros for the rate-scaled tick accumulator.
// Used by rate_scaled_tick_accumulator.sv; needs clk and rst_n in scope.
`ifndef RATE_SCALED_TICK_ACCUMULATOR_DEFINES_SVH
`define RATE_SCALED_TICK_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RSTA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RSTA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rsta_pkg.sv
// Shared types and constants for the rate-scaled tick accumulator.
// No dependencies; imported by rate_scaled_tick_accumulator.
package rsta_pkg;

  localparam int ELAPSED_W   = 32;
  localparam int NUM_W       = 16;
  localparam int DEN_W       = 16;
  localparam int CLAMP_W     = 24;
  localparam int TICKS_W     = 16;
  localparam int CFG_W       = 24;
  localparam int CFG_ADDR_W  = 2;
  localparam int PROD_W      = CLAMP_W + NUM_W;   // clamped time times numerator
  localparam int TOT_W       = PROD_W + 2;        // quotient plus remainder, even length
  localparam int DIGIT_W     = 2;                 // bits handled per cycle
  localparam int MUL_STEPS   = NUM_W / DIGIT_W;
  localparam int DIV1_STEPS  = PROD_W / DIGIT_W;
  localparam int DIV2_STEPS  = TOT_W / DIGIT_W;
  localparam int CNT_W       = $clog2(DIV2_STEPS);
  localparam int MPT_DEFAULT = 1000;

  localparam logic [NUM_W-1:0]   RATE_NUM_RST  = NUM_W'(1);
  localparam logic [DEN_W-1:0]   RATE_DEN_RST  = DEN_W'(1);
  localparam logic [CLAMP_W-1:0] CLAMP_RST     = CLAMP_W'(100000);
  localparam logic [TICKS_W-1:0] MAX_TICKS_RST = TICKS_W'(16);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_RATE_NUM  = 2'd0,
    REG_RATE_DEN  = 2'd1,
    REG_CLAMP_US  = 2'd2,
    REG_MAX_TICKS = 2'd3
  } cfg_reg_t;

  localparam logic REQ_ADVANCE = 1'b0;
  localparam logic REQ_CLEAR   = 1'b1;

  typedef struct packed {
    logic                 req_type;
    logic [ELAPSED_W-1:0] elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic [TICKS_W-1:0] ticks;
    logic               capped;
    logic               rate_invalid;
  } out_word_t;

endpackage

### rtl/rate_scaled_tick_accumulator.sv
// Rate-scaled tick accumulator: turns elapsed microseconds into whole ticks.
// Depends on rsta_pkg and rate_scaled_tick_accumulator_defines.svh.
`include "rate_scaled_tick_accumulator_defines.svh"

//  channel | ports                          | moves
//  --------+--------------------------------+------------------------------------
//  input   | in_valid, in_stall, in_word    | one request word (advance or clear)
//  result  | out_valid, out_stall, out_word | one result word per request
//  config  | cfg_we, cfg_addr, cfg_wdata    | one register write per cycle
//
// An advance runs from acceptance to a valid result through 8 multiplier steps, 20
// steps of the first divider (by the denominator), 1 add of the stored remainder,
// 21 steps of the second divider (by TICK_DIVISOR) and 1 to form the result; a
// clear or a zero-denominator advance takes only that last step. One request is
// in work at a time; the next is taken in the cycle after the result is loaded,
// even while a stalled result word waits. Reset is synchronous, active low.
module rate_scaled_tick_accumulator #(
  parameter int TICK_DIVISOR = rsta_pkg::MPT_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rsta_pkg::in_word_t             in_word,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rsta_pkg::out_word_t            out_word,
  input  logic                           cfg_we,
  input  logic [rsta_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rsta_pkg::CFG_W-1:0]     cfg_wdata
);
  import rsta_pkg::*;

  // The remainder always stays below TICK_DIVISOR.
  localparam int RW = $clog2(TICK_DIVISOR + 1);
  localparam logic [RW:0] MPT_C = (RW + 1)'(TICK_DIVISOR);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_DIV1 = 6'b000100,
    ST_ADD  = 6'b001000,
    ST_DIV2 = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [NUM_W-1:0]   num_r;
  logic [DEN_W-1:0]   den_r;
  logic [CLAMP_W-1:0] clamp_r;
  logic [TICKS_W-1:0] max_r;

  // Architectural state: leftover microticks between advances.
  logic [RW-1:0] rem_r, rem_nxt;

  // Working registers of the serial datapath.
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [CLAMP_W-1:0] a_r, a_nxt;          // clamped elapsed time
  logic [PROD_W-1:0]  w_r, w_nxt;          // product, then first quotient
  logic [DEN_W-1:0]   d1_rem_r, d1_rem_nxt;
  logic [TOT_W-1:0]   t_r, t_nxt;          // total, then tick quotient
  logic [RW-1:0]      d2_rem_r, d2_rem_nxt;
  logic               clr_r, clr_nxt;
  logic               inv_r, inv_nxt;

  out_word_t out_r, out_nxt;
  logic      out_valid_r, out_valid_nxt;

  logic in_acc;
  logic out_free;

  // Step results of the serial units.
  logic [CLAMP_W+1:0] mul_pp, mul_sum;
  logic [PROD_W-1:0]  div1_w;
  logic [DEN_W-1:0]   div1_r;
  logic [TOT_W-1:0]   div2_w;
  logic [RW-1:0]      div2_r;
  logic               over;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // Configuration writes. Every index of the port maps to a register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_r   <= RATE_NUM_RST;
      den_r   <= RATE_DEN_RST;
      clamp_r <= CLAMP_RST;
      max_r   <= MAX_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_RATE_NUM:  num_r   <= cfg_wdata[NUM_W-1:0];
        REG_RATE_DEN:  den_r   <= cfg_wdata[DEN_W-1:0];
        REG_CLAMP_US:  clamp_r <= cfg_wdata[CLAMP_W-1:0];
        REG_MAX_TICKS: max_r   <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Multiplier step: add the clamped time times the low numerator digit into
  // the upper half, then shift the pair right by one digit. The numerator sits
  // in the low half of w_r at the start and is replaced by product bits.
  always_comb begin
    unique case (w_r[1:0])
      2'd0:    mul_pp = '0;
      2'd1:    mul_pp = {2'b00, a_r};
      2'd2:    mul_pp = {1'b0, a_r, 1'b0};
      2'd3:    mul_pp = {2'b00, a_r} + {1'b0, a_r, 1'b0};
      default: mul_pp = '0;
    endcase
    mul_sum = {2'b00, w_r[PROD_W-1:NUM_W]} + mul_pp;
  end

  // First divider: two restoring steps per cycle, quotient bits enter at the
  // bottom of w_r as dividend bits leave the top.
  always_comb begin
    logic [DEN_W:0]    trial;
    logic [DEN_W-1:0]  r;
    logic [PROD_W-1:0] w;
    logic              qb;
    r = d1_rem_r;
    w = w_r;
    for (int j = 0; j < DIGIT_W; j++) begin
      trial = {r, w[PROD_W-1]};
      qb    = (trial >= {1'b0, den_r});
      if (qb) begin
        r = DEN_W'(trial - {1'b0, den_r});
      end else begin
        r = trial[DEN_W-1:0];
      end
      w = {w[PROD_W-2:0], qb};
    end
    div1_r = r;
    div1_w = w;
  end

  // Second divider, by the fixed number of microticks per tick.
  always_comb begin
    logic [RW:0]      trial;
    logic [RW-1:0]    r;
    logic [TOT_W-1:0] w;
    logic             qb;
    r = d2_rem_r;
    w = t_r;
    for (int j = 0; j < DIGIT_W; j++) begin
      trial = {r, w[TOT_W-1]};
      qb    = (trial >= MPT_C);
      if (qb) begin
        r = RW'(trial - MPT_C);
      end else begin
        r = trial[RW-1:0];
      end
      w = {w[TOT_W-2:0], qb};
    end
    div2_r = r;
    div2_w = w;
  end

  // Tick count above the per-advance ceiling.
  assign over = (|t_r[TOT_W-1:TICKS_W]) || (t_r[TICKS_W-1:0] > max_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    a_nxt         = a_r;
    w_nxt         = w_r;
    d1_rem_nxt    = d1_rem_r;
    t_nxt         = t_r;
    d2_rem_nxt    = d2_rem_r;
    clr_nxt       = clr_r;
    inv_nxt       = inv_r;
    rem_nxt       = rem_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          clr_nxt = (in_word.req_type == REQ_CLEAR);
          inv_nxt = (den_r == '0);
          if (in_word.elapsed_us > {{(ELAPSED_W-CLAMP_W){1'b0}}, clamp_r}) begin
            a_nxt = clamp_r;
          end else begin
            a_nxt = in_word.elapsed_us[CLAMP_W-1:0];
          end
          w_nxt      = {{CLAMP_W{1'b0}}, num_r};
          d1_rem_nxt = '0;
          cnt_nxt    = CNT_W'(MUL_STEPS - 1);
          if (in_word.req_type == REQ_CLEAR || den_r == '0) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        w_nxt = {mul_sum, w_r[NUM_W-1:DIGIT_W]};
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(DIV1_STEPS - 1);
          state_nxt = ST_DIV1;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_DIV1: begin
        w_nxt      = div1_w;
        d1_rem_nxt = div1_r;
        if (cnt_r == '0) begin
          state_nxt = ST_ADD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_ADD: begin
        t_nxt      = {2'b00, w_r} + TOT_W'(rem_r);
        d2_rem_nxt = '0;
        cnt_nxt    = CNT_W'(DIV2_STEPS - 1);
        state_nxt  = ST_DIV2;
      end
      ST_DIV2: begin
        t_nxt      = div2_w;
        d2_rem_nxt = div2_r;
        if (cnt_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ST_FIN: begin
        // Hold here until the output register can take the word.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          out_nxt       = '0;
          if (clr_r) begin
            rem_nxt = '0;
          end else if (inv_r) begin
            out_nxt.rate_invalid = 1'b1;
          end else if (over) begin
            out_nxt.ticks  = max_r;
            out_nxt.capped = 1'b1;
            rem_nxt        = '0;
          end else begin
            out_nxt.ticks = t_r[TICKS_W-1:0];
            rem_nxt       = d2_rem_r;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rem_r       <= '0;
      cnt_r       <= '0;
      clr_r       <= 1'b0;
      inv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rem_r       <= rem_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      inv_r       <= inv_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    a_r      <= a_nxt;
    w_r      <= w_nxt;
    d1_rem_r <= d1_rem_nxt;
    t_r      <= t_nxt;
    d2_rem_r <= d2_rem_nxt;
    out_r    <= out_nxt;
  end

  // The stored remainder never reaches a whole tick.
  `RSTA_ASSERT_IMPL(a_rem_below_tick, 1'b1, {1'b0, rem_r} < MPT_C, "remainder reached a whole tick")
  // A result word never reports a cap and an invalid rate together.
  `RSTA_ASSERT_IMPL(a_flags_exclusive, out_valid_r, !(out_r.capped && out_r.rate_invalid), "capped and rate_invalid both set")
  // An accepted request always starts work.
  `RSTA_ASSERT_NEXT(a_accept_busy, in_acc, state_r != ST_IDLE, "accepted request left the block idle")
  // A finished request with a free output slot always produces a word.
  `RSTA_ASSERT_NEXT(a_fin_delivers, state_r == ST_FIN && out_free, out_valid_r && state_r == ST_IDLE, "finished request produced no word")

endmodule
